// ----- rtl/sha_pkg.sv -----
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_req;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage

// ----- rtl/sha_fifo.sv -----
module sha_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sha_pkg::t_req i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sha_pkg::t_req o_data
);
    import sha_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_req            r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            w_we, w_re;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_we    = i_push && !o_full;
    assign w_re    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_we) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_re) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(w_we) - (AW+1)'(w_re);
        end
    end
endmodule

// ----- rtl/sha_engine.sv -----
module sha_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  sha_pkg::t_req i_req,
    output logic          o_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [31:0]   o_digest_word,
    output logic [2:0]    o_word_index,
    output logic          o_final_word
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_TAKE, S_ROUND, S_PAD, S_LEN, S_ADD, S_OUT
    } t_state;

    t_state        r_state;
    logic [31:0]   r_h [8];
    logic [31:0]   r_v [8];
    logic [31:0]   r_w [16];
    logic [5:0]    r_pos;
    logic [63:0]   r_bits;
    logic [63:0]   r_len;
    logic [5:0]    r_rnd;
    logic [2:0]    r_lenk;
    logic [2:0]    r_oidx;
    logic          r_fin;       // 0x80 already placed
    t_state        r_ret;       // state after compression

    logic [31:0] w_wt, w_s0, w_s1, w_wn, w_ch, w_maj, w_b0, w_b1, w_t1, w_t2;
    logic [7:0]  w_byte;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // place one byte big-endian; the first byte of a word clears the rest
    function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] word_out;
        word_out = word;
        case (lane)
            2'd0: word_out = {b, 24'h000000};
            2'd1: word_out[23:16] = b;
            2'd2: word_out[15:8] = b;
            default: word_out[7:0] = b;
        endcase
        return word_out;
    endfunction

    // schedule: r_w is a sliding window, r_w[0] is w[t]
    assign w_wt  = r_w[0];
    assign w_s0  = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1  = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_wn  = r_w[0] + w_s0 + r_w[9] + w_s1;
    assign w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_b0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign w_b1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign w_t1  = r_v[7] + w_b1 + w_ch + round_k(r_rnd) + w_wt;
    assign w_t2  = w_b0 + w_maj;

    // length byte, most significant first
    assign w_byte = r_len[63 - 8*r_lenk -: 8];

    assign o_pop         = (r_state == S_TAKE) && !i_empty;
    assign o_empty       = (r_state != S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_final_word  = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_pos   <= '0;
            r_bits  <= '0;
            r_fin   <= 1'b0;
            r_oidx  <= '0;
            r_rnd   <= '0;
            r_lenk  <= '0;
            r_ret   <= S_TAKE;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= init_h(3'(i));
            end
        end else begin
            case (r_state)
                S_TAKE: begin
                    if (!i_empty) begin
                        if (i_req.byte_valid) begin
                            r_w[r_pos[5:2]] <= put_byte(r_w[r_pos[5:2]], r_pos[1:0],
                                                        i_req.data_byte);
                            r_pos  <= r_pos + 6'd1;
                            r_bits <= r_bits + 64'd8;
                        end
                        if (i_req.end_of_message) begin
                            r_len <= i_req.byte_valid ? r_bits + 64'd8 : r_bits;
                            r_fin <= 1'b0;
                        end
                        if (i_req.byte_valid && r_pos == 6'd63) begin
                            // block full: compress, then pad if closing
                            r_rnd <= '0;
                            for (int i = 0; i < 8; i++) begin
                                r_v[i] <= r_h[i];
                            end
                            r_state <= S_ROUND;
                            r_ret   <= i_req.end_of_message ? S_PAD : S_TAKE;
                        end else if (i_req.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    // 0x80 first, then zeros up to the length field
                    r_w[r_pos[5:2]] <= put_byte(r_w[r_pos[5:2]], r_pos[1:0],
                                                r_fin ? 8'h00 : PAD_BYTE);
                    r_fin <= 1'b1;
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd55) begin
                        r_state <= S_LEN;
                        r_lenk  <= '0;
                    end else if (r_pos == 6'd63) begin
                        r_rnd <= '0;
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_h[i];
                        end
                        r_state <= S_ROUND;
                        r_ret   <= S_PAD;
                    end
                end
                S_LEN: begin
                    r_w[r_pos[5:2]] <= put_byte(r_w[r_pos[5:2]], r_pos[1:0], w_byte);
                    r_pos  <= r_pos + 6'd1;
                    r_lenk <= r_lenk + 3'd1;
                    if (r_pos == 6'd63) begin
                        r_rnd <= '0;
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_h[i];
                        end
                        r_state <= S_ROUND;
                        r_ret   <= S_OUT;
                    end
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= w_wn;
                    r_rnd   <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_pos   <= '0;
                    r_oidx  <= '0;
                    r_state <= r_ret;
                end
                S_OUT: begin
                    if (i_pop) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_state <= S_TAKE;
                            r_pos   <= '0;
                            r_bits  <= '0;
                            r_fin   <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= init_h(3'(i));
                            end
                        end
                    end
                end
                default: r_state <= S_TAKE;
            endcase
        end
    end
endmodule

// ----- rtl/sha256_message_hasher_core.sv -----
// SHA-256 byte-stream hasher: a request queue feeds a one-round-per-cycle engine.
// Bytes are taken one per cycle while filling, whenever the queue is not empty; each full
// block then runs 64 rounds and one chaining add before the next byte is taken.
// After the closing request the padded last block is compressed, and a second block too
// when it held 56..64 bytes; then one digest word per cycle is popped while pop is held.
// Reset (synchronous, active low) empties the queue and loads the initial hash values.
module sha256_message_hasher_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_final_word
);
    import sha_pkg::*;

    t_req w_in, w_q;
    logic w_q_empty, w_q_pop;

    // pack the request fields for the queue
    assign w_in = '{data_byte: i_data_byte, byte_valid: i_byte_valid,
                    end_of_message: i_end_of_message};

    sha_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_in),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q)
    );

    sha_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_q_empty),
        .i_req         (w_q),
        .o_pop         (w_q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_final_word  (o_final_word)
    );
endmodule
